// ===== rtl/core/triangle_scanline_span_gen_defines.svh =====
// Assertion macros for the triangle span generator.
// Used by the top level; expects clk_i and rst_ni in scope.
`ifndef TRIANGLE_SCANLINE_SPAN_GEN_DEFINES_SVH
`define TRIANGLE_SCANLINE_SPAN_GEN_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define TSG_ASSERT_NOW(label, pre, post, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |-> (post)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define TSG_ASSERT_NEXT(label, pre, post, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error(msg);

`endif

// ===== rtl/core/tsg_pkg.sv =====
// Shared types for the triangle span generator.
// Beat structs, controller/datapath command and status, divider select codes.
`timescale 1ns / 1ps

package tsg_pkg;

  localparam int unsigned CoordW = 6;
  localparam int unsigned ColorW = 24;

  typedef struct packed {
    logic [CoordW-1:0] ax;
    logic [CoordW-1:0] ay;
    logic [CoordW-1:0] bx;
    logic [CoordW-1:0] by_coord;
    logic [CoordW-1:0] cx;
    logic [CoordW-1:0] cy;
    logic [ColorW-1:0] fill_color;
  } tri_in_t;

  typedef struct packed {
    logic [CoordW-1:0] row;
    logic [CoordW-1:0] span_start;
    logic [CoordW-1:0] span_end;
    logic [ColorW-1:0] span_color;
    logic              last_span;
  } span_out_t;

  // Which edge the shared divider works on.
  typedef enum logic [1:0] {
    DIV_LONG,
    DIV_LOW,
    DIV_UP
  } div_sel_e;

  typedef struct packed {
    logic     load;
    logic     div_start;
    div_sel_e div_sel;
    logic     row_step;
  } dp_cmd_t;

  typedef struct packed {
    logic flat;
    logic div_done;
    logic last_row;
  } dp_status_t;

endpackage

// ===== rtl/core/tsg_div.sv =====
// Restoring unsigned divider, one quotient bit per cycle.
// Depends on tsg_pkg for the coordinate width.
`timescale 1ns / 1ps

module tsg_div
  import tsg_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic [CoordW-1:0] dividend_i,
  input  logic [CoordW-1:0] divisor_i,
  output logic              done_o,
  output logic [CoordW-1:0] quot_o,
  output logic [CoordW-1:0] rem_o
);

  localparam int unsigned CntW = $clog2(CoordW + 1);

  logic [CntW-1:0]   cnt_q, cnt_d;
  logic              done_q, done_d;
  logic [CoordW-1:0] quot_q, quot_d;
  logic [CoordW-1:0] rem_q, rem_d;
  logic [CoordW-1:0] den_q, den_d;
  logic [CoordW:0]   rem_sh;
  logic              ge;

  assign rem_sh = {rem_q, quot_q[CoordW-1]};
  assign ge     = rem_sh >= {1'b0, den_q};

  always_comb begin
    cnt_d  = cnt_q;
    done_d = 1'b0;
    quot_d = quot_q;
    rem_d  = rem_q;
    den_d  = den_q;
    if (start_i) begin
      cnt_d  = CntW'(CoordW);
      quot_d = dividend_i;
      rem_d  = '0;
      den_d  = divisor_i;
    end else if (cnt_q != '0) begin
      cnt_d  = cnt_q - CntW'(1);
      quot_d = {quot_q[CoordW-2:0], ge};
      rem_d  = ge ? CoordW'(rem_sh - {1'b0, den_q}) : rem_sh[CoordW-1:0];
      done_d = (cnt_q == CntW'(1));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quot_q <= quot_d;
    rem_q  <= rem_d;
    den_q  <= den_d;
  end

  assign done_o = done_q;
  assign quot_o = quot_q;
  assign rem_o  = rem_q;

endmodule

// ===== rtl/core/tsg_datapath.sv =====
// Datapath: vertex sort, edge step setup through the divider, per-row edge
// accumulators and the registered span output. Depends on tsg_pkg, tsg_div.
`timescale 1ns / 1ps

module tsg_datapath
  import tsg_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  tri_in_t    tri_i,
  input  dp_cmd_t    cmd_i,
  output dp_status_t status_o,
  output logic       span_valid_o,
  output span_out_t  span_o
);

  typedef struct packed {
    logic [CoordW-1:0] x;
    logic [CoordW-1:0] y;
  } vtx_t;

  // Quotient and remainder of delta * i / den, kept incrementally.
  typedef struct packed {
    logic [CoordW-1:0] q;
    logic [CoordW-1:0] r;
  } acc_t;

  function automatic logic [CoordW-1:0] edge_x(logic [CoordW-1:0] base, logic neg,
                                              logic [CoordW-1:0] q);
    logic [CoordW:0] s;
    s = neg ? ({1'b0, base} - {1'b0, q}) : ({1'b0, base} + {1'b0, q});
    return s[CoordW-1:0];
  endfunction

  function automatic acc_t acc_step(acc_t a, acc_t stp, logic [CoordW-1:0] den);
    logic [CoordW:0] rs;
    acc_t            n;
    rs = {1'b0, a.r} + {1'b0, stp.r};
    if (rs >= {1'b0, den}) begin
      n.r = CoordW'(rs - {1'b0, den});
      n.q = a.q + stp.q + CoordW'(1);
    end else begin
      n.r = rs[CoordW-1:0];
      n.q = a.q + stp.q;
    end
    return n;
  endfunction

  // Three compare-and-swap stages, swapping only on strictly greater y.
  vtx_t s0, s1, s2;
  always_comb begin
    vtx_t a, b, c, t;
    a = '{x: tri_i.ax, y: tri_i.ay};
    b = '{x: tri_i.bx, y: tri_i.by_coord};
    c = '{x: tri_i.cx, y: tri_i.cy};
    t = a;
    if (a.y > b.y) begin
      t = a; a = b; b = t;
    end
    if (a.y > c.y) begin
      t = a; a = c; c = t;
    end
    if (b.y > c.y) begin
      t = b; b = c; c = t;
    end
    s0 = a;
    s1 = b;
    s2 = c;
  end

  logic flat_in;
  assign flat_in = ((tri_i.ay == tri_i.by_coord) && (tri_i.by_coord == tri_i.cy)) ||
                   ((tri_i.ax == tri_i.bx) && (tri_i.bx == tri_i.cx));

  vtx_t              v0_q, v1_q, v2_q;
  logic [ColorW-1:0] color_q;
  logic              flat_q;
  logic [CoordW-1:0] i_q;
  acc_t              acc_long_q, acc_low_q, acc_up_q;
  acc_t              stp_long_q, stp_low_q, stp_up_q;
  logic              valid_q;
  span_out_t         span_q;

  logic [CoordW-1:0] h, h_low, h_up;
  logic              neg_long, neg_low, neg_up;
  logic [CoordW-1:0] abs_long, abs_low, abs_up;

  assign h     = v2_q.y - v0_q.y;
  assign h_low = v1_q.y - v0_q.y;
  assign h_up  = v2_q.y - v1_q.y;

  assign neg_long = v2_q.x < v0_q.x;
  assign neg_low  = v1_q.x < v0_q.x;
  assign neg_up   = v2_q.x < v1_q.x;
  assign abs_long = neg_long ? (v0_q.x - v2_q.x) : (v2_q.x - v0_q.x);
  assign abs_low  = neg_low ? (v0_q.x - v1_q.x) : (v1_q.x - v0_q.x);
  assign abs_up   = neg_up ? (v1_q.x - v2_q.x) : (v2_q.x - v1_q.x);

  logic [CoordW-1:0] div_num, div_den, div_quot, div_rem;
  logic              div_done;

  always_comb begin
    case (cmd_i.div_sel)
      DIV_LONG: begin
        div_num = abs_long;
        div_den = h;
      end
      DIV_LOW: begin
        div_num = abs_low;
        div_den = h_low;
      end
      DIV_UP: begin
        div_num = abs_up;
        div_den = h_up;
      end
      default: begin
        div_num = '0;
        div_den = '0;
      end
    endcase
  end

  tsg_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i (div_num),
    .divisor_i  (div_den),
    .done_o     (div_done),
    .quot_o     (div_quot),
    .rem_o      (div_rem)
  );

  // Row selection and span ends.
  logic              upper;
  logic [CoordW-1:0] xa, xb;
  span_out_t         span_d;

  assign upper = (i_q > h_low) || (h_low == '0);
  assign xa    = edge_x(v0_q.x, neg_long, acc_long_q.q);
  assign xb    = upper ? edge_x(v1_q.x, neg_up, acc_up_q.q)
                       : edge_x(v0_q.x, neg_low, acc_low_q.q);

  always_comb begin
    span_d.row        = v0_q.y + i_q;
    span_d.span_start = (xa > xb) ? xb : xa;
    span_d.span_end   = (xa > xb) ? xa : xb;
    span_d.span_color = color_q;
    span_d.last_span  = (i_q == h);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= cmd_i.row_step;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      v0_q       <= s0;
      v1_q       <= s1;
      v2_q       <= s2;
      color_q    <= tri_i.fill_color;
      flat_q     <= flat_in;
      i_q        <= '0;
      acc_long_q <= '0;
      acc_low_q  <= '0;
      acc_up_q   <= '0;
    end
    if (div_done) begin
      case (cmd_i.div_sel)
        DIV_LONG: stp_long_q <= '{q: div_quot, r: div_rem};
        DIV_LOW:  stp_low_q  <= '{q: div_quot, r: div_rem};
        DIV_UP:   stp_up_q   <= '{q: div_quot, r: div_rem};
        default:  ;
      endcase
    end
    if (cmd_i.row_step) begin
      i_q        <= i_q + CoordW'(1);
      acc_long_q <= acc_step(acc_long_q, stp_long_q, h);
      acc_low_q  <= acc_step(acc_low_q, stp_low_q, h_low);
      // upper edge starts moving once the middle vertex row is reached
      if (i_q >= h_low) begin
        acc_up_q <= acc_step(acc_up_q, stp_up_q, h_up);
      end
      span_q <= span_d;
    end
  end

  assign status_o.flat     = flat_q;
  assign status_o.div_done = div_done;
  assign status_o.last_row = (i_q == h);
  assign span_valid_o      = valid_q;
  assign span_o            = span_q;

endmodule

// ===== rtl/core/tsg_ctrl.sv =====
// Controller FSM: accept, flat check, long/low/up edge divisions, row loop.
// Depends on tsg_pkg for command and status types.
`timescale 1ns / 1ps

module tsg_ctrl
  import tsg_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       start,
  output logic       busy,
  output dp_cmd_t    cmd_o,
  input  dp_status_t status_i
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_DIV_ISSUE,
    ST_DIV_WAIT,
    ST_ROWS
  } state_e;

  state_e   state_q;
  div_sel_e sel_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      sel_q   <= DIV_LONG;
    end else begin
      case (state_q)
        ST_IDLE: begin
          if (start) begin
            state_q <= ST_CHECK;
          end
        end
        ST_CHECK: begin
          sel_q   <= DIV_LONG;
          state_q <= status_i.flat ? ST_IDLE : ST_DIV_ISSUE;
        end
        ST_DIV_ISSUE: begin
          state_q <= ST_DIV_WAIT;
        end
        ST_DIV_WAIT: begin
          if (status_i.div_done) begin
            case (sel_q)
              DIV_LONG: begin
                sel_q   <= DIV_LOW;
                state_q <= ST_DIV_ISSUE;
              end
              DIV_LOW: begin
                sel_q   <= DIV_UP;
                state_q <= ST_DIV_ISSUE;
              end
              DIV_UP:  state_q <= ST_ROWS;
              default: state_q <= ST_IDLE;
            endcase
          end
        end
        ST_ROWS: begin
          if (status_i.last_row) begin
            state_q <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign busy            = (state_q != ST_IDLE);
  assign cmd_o.load      = start && (state_q == ST_IDLE);
  assign cmd_o.div_start = (state_q == ST_DIV_ISSUE);
  assign cmd_o.div_sel   = sel_q;
  assign cmd_o.row_step  = (state_q == ST_ROWS);

endmodule

// ===== rtl/core/triangle_scanline_span_gen.sv =====
// Top level of the triangle span generator.
// Depends on tsg_pkg, tsg_ctrl, tsg_datapath and the assertion header.
`timescale 1ns / 1ps
`include "triangle_scanline_span_gen_defines.svh"

// Scanline span generator. A triangle beat is taken on a clock edge where
// start is high and busy is low. For each row from the lowest to the highest
// vertex the block emits one span beat, flagged by span_valid_o for exactly
// one cycle; the receiver cannot stall, so it must take every beat as it
// comes. Span ends are ordered (start <= end) and the final span of the
// triangle carries last_span. A triangle with all y equal or all x equal
// produces no beats at all.
//
// Sequence: after the accept edge, a check state tests for a flat triangle, then
// the shared restoring divider computes the per-row step (quotient and
// remainder) of the long, lower and upper edges in three runs (an issue
// state, six quotient bits, then the result handed over). The row loop
// then emits one span per cycle for the h + 1 rows, where h is the vertex y
// span. The last span beat sits on the ports in the first cycle with busy
// low. A flat triangle holds busy for a single cycle.
//
// Edge x positions use the exact truncating quotient of dx * i / h, kept as a
// running quotient and remainder so each row needs only an add and one
// compare-subtract per edge.
module triangle_scanline_span_gen
  import tsg_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      start,
  output logic      busy,
  input  tri_in_t   tri_i,
  output logic      span_valid_o,
  output span_out_t span_o
);

  dp_cmd_t    cmd;
  dp_status_t status;

  tsg_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start    (start),
    .busy     (busy),
    .cmd_o    (cmd),
    .status_i (status)
  );

  tsg_datapath u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .tri_i        (tri_i),
    .cmd_i        (cmd),
    .status_o     (status),
    .span_valid_o (span_valid_o),
    .span_o       (span_o)
  );

  // Span ends come out ordered.
  `TSG_ASSERT_NOW(a_span_ordered, span_valid_o,
                  span_o.span_start <= span_o.span_end, "span ends out of order")

  // Nothing follows the last span of a triangle on the next cycle.
  `TSG_ASSERT_NEXT(a_last_ends, span_valid_o && span_o.last_span, !span_valid_o,
                   "beat after last span")

  // Spans within a triangle are back to back on consecutive rows.
  `TSG_ASSERT_NEXT(a_rows_step, span_valid_o && !span_o.last_span,
                   span_valid_o && (span_o.row == $past(span_o.row) + 6'd1),
                   "span rows not consecutive")

  // An accepted triangle makes the block busy.
  `TSG_ASSERT_NEXT(a_accept_busy, start && !busy, busy, "busy not raised after accept")

endmodule

// ===== dv/triangle_scanline_span_gen_tb.sv =====
// Self-checking testbench for triangle_scanline_span_gen.
// Needs tsg_pkg and the RTL only. Checks every span beat against a built-in span predictor.
`timescale 1ns / 1ps

module triangle_scanline_span_gen_tb
  import tsg_pkg::*;
;

  localparam int ImageSize = 64;
  localparam int ClkHalf   = 5;

  // Random phases: sender idle rate and number of non-flat triangles each.
  localparam int PhaseTris = 100;

  // Triangle in, spans out. Works out the spans of each accepted triangle and
  // checks the beats in order. Vertices are sorted by y with three
  // compare-and-swap stages that swap only on a strictly greater y, so the
  // order of equal-y vertices matters for which edge is "short".
  class span_book;
    span_out_t exp_spans[$];
    int        errors;
    int        vx[3];
    int        vy[3];

    function new();
      errors = 0;
    endfunction

    function void sort_pair(int lo, int hi);
      int tx;
      int ty;
      if (vy[lo] > vy[hi]) begin
        tx = vx[lo]; ty = vy[lo];
        vx[lo] = vx[hi]; vy[lo] = vy[hi];
        vx[hi] = tx; vy[hi] = ty;
      end
    endfunction

    function logic [CoordW-1:0] clamp_col(int x);
      if (x < 0) x = 0;
      if (x > ImageSize - 1) x = ImageSize - 1;
      return x[CoordW-1:0];
    endfunction

    // Queue the spans of one accepted triangle; returns how many.
    function int add_triangle(tri_in_t t);
      int        h;
      int        h_low;
      int        rows;
      int        xa;
      int        xb;
      int        tmp;
      bit        upper;
      span_out_t s;
      vx[0] = t.ax; vy[0] = t.ay;
      vx[1] = t.bx; vy[1] = t.by_coord;
      vx[2] = t.cx; vy[2] = t.cy;
      // Degenerate: all y equal or all x equal gives nothing.
      if ((vy[0] == vy[1] && vy[1] == vy[2]) || (vx[0] == vx[1] && vx[1] == vx[2]))
        return 0;
      sort_pair(0, 1);
      sort_pair(0, 2);
      sort_pair(1, 2);
      h     = vy[2] - vy[0];
      h_low = vy[1] - vy[0];
      rows  = h + 1;
      if (vy[0] + h > ImageSize - 1) rows = ImageSize - vy[0];
      if (rows < 0) rows = 0;
      for (int i = 0; i < rows; i++) begin
        // Flat bottom runs the whole height on the upper edge.
        upper = (i > h_low) || (h_low == 0);
        // SV int division truncates toward zero, matching the hardware.
        xa = vx[0] + ((vx[2] - vx[0]) * i) / h;
        if (upper)
          xb = vx[1] + ((vx[2] - vx[1]) * (i - h_low)) / (vy[2] - vy[1]);
        else
          xb = vx[0] + ((vx[1] - vx[0]) * i) / h_low;
        if (xa > xb) begin
          tmp = xa; xa = xb; xb = tmp;
        end
        s.row        = CoordW'(vy[0] + i);
        s.span_start = clamp_col(xa);
        s.span_end   = clamp_col(xb);
        s.span_color = t.fill_color;
        s.last_span  = (i == rows - 1);
        exp_spans.push_back(s);
      end
      return rows;
    endfunction

    function void cmp_field(string name, int unsigned e, int unsigned a);
      if (e != a) begin
        $error("%s mismatch: expected 0x%0h, got 0x%0h", name, e, a);
        errors++;
      end
    endfunction

    function void check_span(span_out_t got);
      span_out_t e;
      if (exp_spans.size() == 0) begin
        $error("span beat with nothing expected: row %0d", got.row);
        errors++;
        return;
      end
      e = exp_spans.pop_front();
      cmp_field("row",        e.row,        got.row);
      cmp_field("span_start", e.span_start, got.span_start);
      cmp_field("span_end",   e.span_end,   got.span_end);
      cmp_field("span_color", e.span_color, got.span_color);
      cmp_field("last_span",  e.last_span,  got.last_span);
    endfunction
  endclass

  logic      clk_i = 1'b0;
  logic      rst_ni = 1'b0;
  logic      start = 1'b0;
  logic      busy;
  tri_in_t   tri_i = '0;
  logic      span_valid_o;
  span_out_t span_o;

  span_book book = new();

  triangle_scanline_span_gen u_top (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start        (start),
    .busy         (busy),
    .tri_i        (tri_i),
    .span_valid_o (span_valid_o),
    .span_o       (span_o)
  );

  always begin
    #ClkHalf clk_i = 1'b1;
    #ClkHalf clk_i = 1'b0;
  end

  // Span beats last one cycle and cannot be stalled: check every one at the
  // edge that takes it. Sampling at posedge sees the pre-edge values.
  always @(posedge clk_i) begin
    if (rst_ni && span_valid_o) book.check_span(span_o);
  end

  function automatic tri_in_t mk_tri(int ax, int ay, int bx, int by_c, int cx, int cy,
                                     int unsigned color);
    tri_in_t t;
    t.ax         = CoordW'(ax);
    t.ay         = CoordW'(ay);
    t.bx         = CoordW'(bx);
    t.by_coord   = CoordW'(by_c);
    t.cx         = CoordW'(cx);
    t.cy         = CoordW'(cy);
    t.fill_color = ColorW'(color);
    return t;
  endfunction

  // One triangle beat. Inputs move at negedge; start stays high from the
  // previous beat unless the sender idles, so back-to-back beats never drop it.
  // The beat is taken at the first posedge that sees busy low.
  task automatic send_tri(input tri_in_t t, input int idle_pct, output int n_spans);
    @(negedge clk_i);
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(negedge clk_i);
    end
    start <= 1'b1;
    tri_i <= t;
    do begin
      @(posedge clk_i);
    end while (busy);
    n_spans = book.add_triangle(t);
  endtask

  // Random triangles with a given sender idle rate, until n_tris of them were
  // non-flat. Mix: flat noise, short triangles, flat top/bottom, and fully
  // random ones spanning up to the whole image height.
  task automatic run_random(input int idle_pct, input int n_tris);
    tri_in_t t;
    int      good;
    int      n;
    int      kind;
    int      base;
    good = 0;
    while (good < n_tris) begin
      t.ax         = CoordW'($urandom);
      t.ay         = CoordW'($urandom);
      t.bx         = CoordW'($urandom);
      t.by_coord   = CoordW'($urandom);
      t.cx         = CoordW'($urandom);
      t.cy         = CoordW'($urandom);
      t.fill_color = ColorW'($urandom);
      kind = $urandom_range(99);
      if (kind < 10) begin
        // Degenerate noise: shared y or shared x.
        if ($urandom_range(1)) begin
          t.by_coord = t.ay; t.cy = t.ay;
        end else begin
          t.bx = t.ax; t.cx = t.ax;
        end
      end else if (kind < 40) begin
        // Short triangles keep the rows count small.
        base       = $urandom_range(ImageSize - 8);
        t.ay       = CoordW'(base + $urandom_range(7));
        t.by_coord = CoordW'(base + $urandom_range(7));
        t.cy       = CoordW'(base + $urandom_range(7));
      end else if (kind < 55) begin
        // Two vertices on one row: flat bottom or flat top after sorting.
        case ($urandom_range(2))
          0: t.by_coord = t.ay;
          1: t.cy = t.ay;
          default: t.cy = t.by_coord;
        endcase
      end
      send_tri(t, idle_pct, n);
      if (n > 0) good++;
    end
  endtask

  initial begin
    tri_in_t dir_tris[$];
    int      n;

    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed corners.
    dir_tris.push_back(mk_tri( 5, 10, 20, 10, 40, 10, 32'h000000)); // all y equal
    dir_tris.push_back(mk_tri(30,  0, 30, 40, 30, 63, 32'hFFFFFF)); // all x equal
    dir_tris.push_back(mk_tri( 0,  0,  0,  0,  0,  0, 32'h123456)); // single point
    dir_tris.push_back(mk_tri(63, 63, 63, 63, 63, 63, 32'hFFFFFF));
    dir_tris.push_back(mk_tri( 0,  0, 63,  0,  0, 63, 32'hFFFFFF)); // flat bottom, full
    dir_tris.push_back(mk_tri(63, 63,  0, 63, 63,  0, 32'h000000)); // flat top, full
    dir_tris.push_back(mk_tri( 0,  0, 63, 31, 10, 63, 32'hAAAAAA)); // bend to the right
    dir_tris.push_back(mk_tri(63,  0,  0, 31, 50, 63, 32'h555555)); // negative slopes
    dir_tris.push_back(mk_tri( 0, 63, 63,  0, 20, 40, 32'hFF0000)); // reversed order
    // One triangle in all six vertex orders: exercises every swap stage.
    dir_tris.push_back(mk_tri(10,  5, 50, 30, 25, 60, 32'h00FF00));
    dir_tris.push_back(mk_tri(10,  5, 25, 60, 50, 30, 32'h00FF00));
    dir_tris.push_back(mk_tri(50, 30, 10,  5, 25, 60, 32'h00FF00));
    dir_tris.push_back(mk_tri(50, 30, 25, 60, 10,  5, 32'h00FF00));
    dir_tris.push_back(mk_tri(25, 60, 10,  5, 50, 30, 32'h00FF00));
    dir_tris.push_back(mk_tri(25, 60, 50, 30, 10,  5, 32'h00FF00));
    dir_tris.push_back(mk_tri( 0,  0, 20, 20, 40, 40, 32'h0000FF)); // collinear
    dir_tris.push_back(mk_tri(10, 10, 10, 10, 50, 40, 32'h808080)); // repeated vertex
    dir_tris.push_back(mk_tri( 0,  7, 63,  7, 30,  8, 32'h7F7F7F)); // two rows
    dir_tris.push_back(mk_tri(40, 20, 10, 20, 25, 50, 32'h010101)); // equal y, x order
    dir_tris.push_back(mk_tri(63,  0,  0, 63, 63, 63, 32'hFEFEFE));
    dir_tris.push_back(mk_tri( 1, 62, 62,  1, 32, 32, 32'hC3C3C3));
    dir_tris.push_back(mk_tri(20,  0, 20, 63, 21, 30, 32'h3C3C3C)); // thin sliver
    foreach (dir_tris[k]) send_tri(dir_tris[k], 0, n);

    run_random(14, PhaseTris);
    run_random(69, PhaseTris);
    run_random(0,  PhaseTris);

    @(negedge clk_i);
    start <= 1'b0;

    // Drain, then give the block time for any stray beat.
    while (book.exp_spans.size() != 0) @(posedge clk_i);
    repeat (120) @(posedge clk_i);

    if (book.errors == 0 && book.exp_spans.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  // Watchdog: stops the run and reports failure if it does not finish.
  initial begin
    #5_000_000;
    $display("TEST FAILED");
    $finish;
  end

endmodule
